// File: rtl/core/dpf_pkg.sv
// shared types and constants of the duplicate packet filter
package dpf_pkg;

   // slot numbers are carried at the width of the largest supported table
   localparam int SLOT_MAX_W = 8;
   localparam int RSP_SLOT_W = 5;
   localparam int CSR_ADDR_W = 3;

   typedef logic [SLOT_MAX_W-1:0] slot_type;

   // item modes
   localparam logic MODE_CHECK  = 1'b0;
   localparam logic MODE_RECORD = 1'b1;

   // register indexes, taken from paddr bit 2
   localparam logic REG_RETENTION = 1'b0;
   localparam logic REG_OUR_NODE  = 1'b1;

   // reset values of the registers
   localparam logic [31:0] RETENTION_RESET = 32'(5 * 60 * 1000);
   localparam logic [31:0] OUR_NODE_RESET  = 32'd1;

   // item held in the block while its scan runs
   typedef struct packed {
      logic        mode;
      logic [31:0] source_node;
      logic [31:0] packet_id;
      logic [2:0]  hop_limit;
      logic [2:0]  hop_start;
      logic [31:0] now_ms;
      logic        pending_match;
   } item_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic        active;
      logic        match_found;
      slot_type    match_slot;
      logic [2:0]  match_hops;
      logic        pick_found;
      slot_type    pick_slot;
      slot_type    oldest_slot;
      logic [31:0] oldest_age;
   } scan_type;

   // entry update broadcast to the row
   typedef struct packed {
      logic        en;
      logic        full;
      logic        set_hops;
      slot_type    slot;
      logic [31:0] source_node;
      logic [31:0] packet_id;
      logic [2:0]  hops;
      logic [31:0] now_ms;
   } wr_type;

endpackage

// File: rtl/core/dpf_if.sv
// item channels of the duplicate packet filter

// request channel
interface dpf_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] source_node;
   logic [31:0] packet_id;
   logic [2:0]  hop_limit;
   logic [2:0]  hop_start;
   logic [31:0] now_ms;
   logic        pending_match;

   modport source (
      output valid, mode, source_node, packet_id, hop_limit, hop_start, now_ms,
             pending_match,
      input  ready
   );
   modport sink (
      input  valid, mode, source_node, packet_id, hop_limit, hop_start, now_ms,
             pending_match,
      output ready
   );
endinterface

// response channel
interface dpf_rsp_if;
   logic       valid;
   logic       ready;
   logic       accept;
   logic       was_seen;
   logic [4:0] slot;

   modport source (
      output valid, accept, was_seen, slot,
      input  ready
   );
   modport sink (
      input  valid, accept, was_seen, slot,
      output ready
   );
endinterface

// File: rtl/core/dpf_cell.sv
// one table entry of the filter and its stage of the search token
module dpf_cell import dpf_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  item_type    item,
   input  logic [31:0] retention,
   input  scan_type    tok_in,
   output scan_type    tok_out,
   input  wr_type      wr
);

   logic        valid_ff;
   logic [2:0]  hops_ff;
   logic [31:0] source_ff;
   logic [31:0] packet_id_ff;
   logic [31:0] last_seen_ff;

   logic [31:0] age;
   logic        match_here;
   logic        free_here;
   logic        older_here;
   scan_type    tok_in_next;
   scan_type    tok_ff;

   // compare this entry against the item
   assign age        = item.now_ms - last_seen_ff;
   assign match_here = !tok_in.match_found && (item.mode == MODE_CHECK) && valid_ff &&
                       (source_ff == item.source_node) && (packet_id_ff == item.packet_id);
   assign free_here  = !tok_in.pick_found && (!valid_ff || (age > retention));
   assign older_here = !tok_in.pick_found && valid_ff && (age > tok_in.oldest_age);

   // token update
   always_comb begin
      tok_in_next = tok_in;
      if (match_here) begin
         tok_in_next.match_found = 1'b1;
         tok_in_next.match_slot  = slot_type'(INDEX);
         tok_in_next.match_hops  = hops_ff;
      end
      if (free_here) begin
         tok_in_next.pick_found = 1'b1;
         tok_in_next.pick_slot  = slot_type'(INDEX);
      end
      if (older_here) begin
         tok_in_next.oldest_slot = slot_type'(INDEX);
         tok_in_next.oldest_age  = age;
      end
   end

   // token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

   // entry storage, written by the broadcast update
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && (wr.slot == slot_type'(INDEX))) begin
         if (wr.full) begin
            valid_ff     <= 1'b1;
            source_ff    <= wr.source_node;
            packet_id_ff <= wr.packet_id;
         end
         if (wr.set_hops) begin
            hops_ff <= wr.hops;
         end
         last_seen_ff <= wr.now_ms;
      end
   end

endmodule

// File: rtl/core/dpf_csr.sv
// configuration registers of the filter behind an apb-style port
module dpf_csr import dpf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output logic [31:0]           retention,
   output logic [31:0]           our_node
);

   logic [31:0] retention_ff;
   logic [31:0] our_node_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         retention_ff <= RETENTION_RESET;
         our_node_ff  <= OUR_NODE_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            REG_RETENTION: retention_ff <= pwdata;
            REG_OUR_NODE:  our_node_ff  <= pwdata;
            default:       retention_ff <= retention_ff;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (paddr[2])
         REG_RETENTION: prdata = retention_ff;
         REG_OUR_NODE:  prdata = our_node_ff;
         default:       prdata = '0;
      endcase
   end

   assign retention = retention_ff;
   assign our_node  = our_node_ff;

endmodule

// File: rtl/core/duplicate_packet_filter.sv
// top level of the duplicate packet filter
// Each accepted item sends a search token down a row of TABLE_ENTRIES cells, one cell per
// cycle; every cell holds one table entry and notes a key match, the first free or expired
// slot and the oldest slot. An item passes from acceptance through the walk through the
// row, the capture of the finished token and the issue of the result together with its
// entry update; the issue waits while an earlier result is still stalled. The input opens
// again when the result is issued, so the block takes no new item before the last result
// is issued. The block takes one item at a time; it takes the next item while the previous
// result still waits, and holds the update until that result is taken. Slot numbers wider
// than five bits are reported modulo 32.
module duplicate_packet_filter import dpf_pkg::*; #(
   parameter int TABLE_ENTRIES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   dpf_req_if.sink               req,
   dpf_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type   state_ff;
   item_type    item_ff;
   logic        start_ff;
   scan_type    res_ff;
   wr_type      wr_ff;
   wr_type      wr_in;
   logic        rsp_valid_ff;
   logic        rsp_accept_ff;
   logic        rsp_was_seen_ff;
   logic [4:0]  rsp_slot_ff;

   logic [31:0] retention;
   logic [31:0] our_node;
   scan_type    tok [TABLE_ENTRIES+1];

   logic        hit;
   logic        improve;
   logic        retry;
   logic        accept_in;
   slot_type    slot_in;

   // configuration registers
   dpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .retention (retention),
      .our_node  (our_node)
   );

   // token entering the first cell
   always_comb begin
      tok[0]        = '0;
      tok[0].active = start_ff;
   end

   // row of cells
   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      dpf_cell #(.INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .item      (item_ff),
         .retention (retention),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1]),
         .wr        (wr_ff)
      );
   end

   // decision from the finished token
   assign hit     = (item_ff.mode == MODE_CHECK) && res_ff.match_found;
   assign improve = item_ff.hop_limit > res_ff.match_hops;
   assign retry   = (item_ff.hop_start != 3'd0) && (item_ff.hop_start == item_ff.hop_limit) &&
                    !item_ff.pending_match;
   assign accept_in = !hit || improve || retry;

   always_comb begin
      if (hit) begin
         slot_in = res_ff.match_slot;
      end else if (res_ff.pick_found) begin
         slot_in = res_ff.pick_slot;
      end else begin
         slot_in = res_ff.oldest_slot;
      end
   end

   // entry update for the chosen slot
   always_comb begin
      wr_in             = '0;
      wr_in.en          = 1'b1;
      wr_in.full        = !hit;
      wr_in.set_hops    = !hit || improve;
      wr_in.slot        = slot_in;
      wr_in.source_node = (item_ff.mode == MODE_RECORD) ? our_node : item_ff.source_node;
      wr_in.packet_id   = item_ff.packet_id;
      wr_in.hops        = item_ff.hop_limit;
      wr_in.now_ms      = item_ff.now_ms;
   end

   // control sequence and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         wr_ff.en     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         wr_ff.en <= 1'b0;
         if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  item_ff.mode          <= req.mode;
                  item_ff.source_node   <= req.source_node;
                  item_ff.packet_id     <= req.packet_id;
                  item_ff.hop_limit     <= req.hop_limit;
                  item_ff.hop_start     <= req.hop_start;
                  item_ff.now_ms        <= req.now_ms;
                  item_ff.pending_match <= req.pending_match;
                  start_ff              <= 1'b1;
                  state_ff              <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (tok[TABLE_ENTRIES].active) begin
                  res_ff   <= tok[TABLE_ENTRIES];
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accept_ff   <= accept_in;
                  rsp_was_seen_ff <= hit;
                  rsp_slot_ff     <= RSP_SLOT_W'(slot_in);
                  wr_ff           <= wr_in;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.accept   = rsp_accept_ff;
   assign rsp.was_seen = rsp_was_seen_ff;
   assign rsp.slot     = rsp_slot_ff;

endmodule

// File: rtl/core/dpf_checker.sv
// port-level checks of the duplicate packet filter and their binding
module dpf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_accept,
   input logic       rsp_was_seen,
   input logic [4:0] rsp_slot
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accept) &&
      $stable(rsp_was_seen) && $stable(rsp_slot))
      else $error("stalled result changed");

   // one item at a time: busy right after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while busy");

   // only a packet already in the table can be refused
   a_reject_needs_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accept |-> rsp_was_seen)
      else $error("refused item that was not seen");

   // reset leaves no result and an open request side
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state after reset");

endmodule

bind duplicate_packet_filter dpf_checker u_dpf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_accept   (rsp.accept),
   .rsp_was_seen (rsp.was_seen),
   .rsp_slot     (rsp.slot)
);

// File: sim/tb_duplicate_packet_filter.sv
// self-checking testbench of the duplicate packet filter: directed table, then random phases
module tb_duplicate_packet_filter;
   import dpf_pkg::*;

   localparam int TABLE_ENTRIES    = 32;
   localparam int ITEM_LATENCY     = TABLE_ENTRIES + 2;
   localparam int TAIL_CYCLES      = 2 * ITEM_LATENCY;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int RANDOM_PER_PHASE = 90;
   localparam int PHASES           = 5;
   localparam int POOL_MAX         = 48;
   localparam int DIRECTED_ROWS    = 18;

   // verdict carried by one result item
   typedef struct packed {
      logic       accept;
      logic       was_seen;
      logic [4:0] slot;
   } verdict_type;

   // directed row: item, and a typed-in verdict where it is obvious
   typedef struct packed {
      item_type    it;
      logic        typed;
      verdict_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dpf_req_if req_ch ();
   dpf_rsp_if rsp_ch ();

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   duplicate_packet_filter #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // mirror of the table and registers
   logic [31:0] retention_reg = RETENTION_RESET;
   logic [31:0] our_node_reg  = OUR_NODE_RESET;
   logic        tbl_valid [TABLE_ENTRIES] = '{default: 1'b0};
   logic [2:0]  tbl_hops  [TABLE_ENTRIES] = '{default: '0};
   logic [31:0] tbl_src   [TABLE_ENTRIES] = '{default: '0};
   logic [31:0] tbl_id    [TABLE_ENTRIES] = '{default: '0};
   logic [31:0] tbl_seen  [TABLE_ENTRIES] = '{default: '0};

   verdict_type verdict_q [$];

   int error_count     = 0;
   int items_sent      = 0;
   int record_items    = 0;
   int results_checked = 0;
   int hit_results     = 0;
   int config_writes   = 0;
   int burst_left      = 0;
   bit hold_off_pending = 1'b0;

   // directed items, starting from reset settings
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // fresh key takes slot 0
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd0, 3'd0, 32'd0, 1'b0}, 1'b1, '{1'b1, 1'b0, 5'd0}},
      // duplicate with no better hops and no retry
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd0, 3'd0, 32'd10, 1'b0}, 1'b1, '{1'b0, 1'b1, 5'd0}},
      // better hops wins even when pending
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd7, 3'd7, 32'd20, 1'b1}, 1'b1, '{1'b1, 1'b1, 5'd0}},
      // original retry with nothing pending
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd7, 3'd7, 32'd30, 1'b0}, 1'b1, '{1'b1, 1'b1, 5'd0}},
      // original retry blocked by a pending frame
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd7, 3'd7, 32'd40, 1'b1}, 1'b1, '{1'b0, 1'b1, 5'd0}},
      // hop start differs from hops: not a retry
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd3, 3'd7, 32'd50, 1'b0}, 1'b1, '{1'b0, 1'b1, 5'd0}},
      // retry with fewer hops than the best
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd6, 3'd6, 32'd60, 1'b0}, 1'b1, '{1'b1, 1'b1, 5'd0}},
      // record ignores the source field and takes the next free slot
      '{'{MODE_RECORD, 32'hDEAD_BEEF, 32'h0, 3'd2, 3'd2, 32'd70, 1'b1}, 1'b1,
        '{1'b1, 1'b0, 5'd1}},
      // record of the same key again takes another slot
      '{'{MODE_RECORD, 32'hDEAD_BEEF, 32'h0, 3'd2, 3'd2, 32'd80, 1'b0}, 1'b1,
        '{1'b1, 1'b0, 5'd2}},
      // lowest of the two recorded copies matches
      '{'{MODE_CHECK, 32'h1, 32'h0, 3'd2, 3'd0, 32'd90, 1'b0}, 1'b1, '{1'b0, 1'b1, 5'd1}},
      // all-ones key at the top of time, slot 0 has expired
      '{'{MODE_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 3'd0, 32'hFFFF_FFFF, 1'b0},
        1'b0, '0},
      // time wraps past zero
      '{'{MODE_CHECK, 32'h0, 32'h0, 3'd0, 3'd0, 32'd100, 1'b0}, 1'b0, '0},
      '{'{MODE_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 3'd7, 32'd110, 1'b0}, 1'b0, '0},
      '{'{MODE_CHECK, 32'h0, 32'hFFFF_FFFF, 3'd1, 3'd1, 32'd120, 1'b1}, 1'b0, '0},
      '{'{MODE_CHECK, 32'hFFFF_FFFF, 32'h0, 3'd5, 3'd0, 32'd130, 1'b1}, 1'b0, '0},
      // timestamp older than the entries looks very old
      '{'{MODE_CHECK, 32'h1234_5678, 32'hA5A5_A5A5, 3'd4, 3'd2, 32'd5, 1'b0}, 1'b0, '0},
      '{'{MODE_RECORD, 32'h0, 32'h5A5A_5A5A, 3'd4, 3'd4, 32'h7FFF_FFFF, 1'b1}, 1'b0, '0},
      // check of a recorded packet under our node, better hops
      '{'{MODE_CHECK, 32'h1, 32'h5A5A_5A5A, 3'd5, 3'd3, 32'h8000_0000, 1'b0}, 1'b0, '0}
   };

   // slot taken by a new key: first free or expired, else the oldest
   function automatic int choose_slot(input logic [31:0] now);
      int          oldest;
      logic [31:0] age;
      logic [31:0] oldest_age;
      oldest = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         age = now - tbl_seen[i];
         if (!tbl_valid[i] || age > retention_reg)
            return i;
         oldest_age = now - tbl_seen[oldest];
         if (age > oldest_age)
            oldest = i;
      end
      return oldest;
   endfunction

   task automatic store_entry(input int s, input logic [31:0] src, input logic [31:0] id,
                              input logic [2:0] hops, input logic [31:0] now);
      tbl_valid[s] = 1'b1;
      tbl_hops[s]  = hops;
      tbl_src[s]   = src;
      tbl_id[s]    = id;
      tbl_seen[s]  = now;
   endtask

   // verdict for one item, updating the mirrored table
   task automatic predict_verdict(input item_type it, output verdict_type v);
      int hit_slot;
      int s;
      hit_slot = -1;
      s = 0;
      v = '0;
      if (it.mode == MODE_RECORD) begin
         s = choose_slot(it.now_ms);
         store_entry(s, our_node_reg, it.packet_id, it.hop_limit, it.now_ms);
         v.accept = 1'b1;
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit_slot < 0 && tbl_valid[i] && tbl_src[i] == it.source_node &&
                tbl_id[i] == it.packet_id)
               hit_slot = i;
         if (hit_slot < 0) begin
            s = choose_slot(it.now_ms);
            store_entry(s, it.source_node, it.packet_id, it.hop_limit, it.now_ms);
            v.accept = 1'b1;
         end else begin
            s = hit_slot;
            v.was_seen = 1'b1;
            tbl_seen[s] = it.now_ms;
            if (it.hop_limit > tbl_hops[s]) begin
               tbl_hops[s] = it.hop_limit;
               v.accept = 1'b1;
            end else begin
               v.accept = (it.hop_start != 3'd0 && it.hop_start == it.hop_limit &&
                           !it.pending_match);
            end
         end
      end
      v.slot = s[4:0];
   endtask

   // offer one item in bursts with random gaps; called and returning at a falling edge
   task automatic offer_item(input item_type it, input logic typed, input verdict_type want);
      int          gap;
      verdict_type predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_ch.mode          <= it.mode;
      req_ch.source_node   <= it.source_node;
      req_ch.packet_id     <= it.packet_id;
      req_ch.hop_limit     <= it.hop_limit;
      req_ch.hop_start     <= it.hop_start;
      req_ch.now_ms        <= it.now_ms;
      req_ch.pending_match <= it.pending_match;
      req_ch.valid         <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      predict_verdict(it, predicted);
      verdict_q.push_back(typed ? want : predicted);
      items_sent++;
      if (it.mode == MODE_RECORD)
         record_items++;
      burst_left--;
      @(negedge clock);
   endtask

   // stop offering and wait until every result is back
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (verdict_q.size() != 0)
         @(negedge clock);
   endtask

   // register write: setup cycle, then access cycle
   task automatic write_reg(input logic idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_RETENTION)
         retention_reg = value;
      else
         our_node_reg = value;
      config_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   function automatic bit field_ok(input string name, input logic [4:0] want,
                                   input logic [4:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // compare each result item with the oldest prediction
   always @(posedge clock) begin : check_results
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.accept, rsp_ch.was_seen, rsp_ch.slot};
         if (verdict_q.size() == 0) begin
            $display("%0t: result with no item outstanding, expected none, got %0d/%0d/%0d",
                     $time, got.accept, got.was_seen, got.slot);
            error_count++;
         end else begin
            want = verdict_q.pop_front();
            if (!field_ok("accept", 5'(want.accept), 5'(got.accept)))
               error_count++;
            if (!field_ok("was_seen", 5'(want.was_seen), 5'(got.was_seen)))
               error_count++;
            if (!field_ok("slot", want.slot, got.slot))
               error_count++;
         end
         results_checked++;
         if (got.was_seen === 1'b1)
            hit_results++;
      end
   end

   // receiver: stall pattern stepping through always, mostly, rarely and alternately ready, plus one long hold-off
   initial begin : receiver
      int rx_cycle;
      rx_cycle = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rx_cycle++;
         case ((rx_cycle / 50) % 4)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ch.ready <= rx_cycle[0];
         endcase
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // stimulus
   initial begin : stimulus
      item_type    it;
      logic [31:0] pool_src [POOL_MAX];
      logic [31:0] pool_id  [POOL_MAX];
      logic [31:0] now_clock;
      logic [31:0] retention_set;
      logic [31:0] node_set;
      int          pool_size;
      int          span;
      int          k;

      req_ch.valid         = 1'b0;
      req_ch.mode          = MODE_CHECK;
      req_ch.source_node   = '0;
      req_ch.packet_id     = '0;
      req_ch.hop_limit     = '0;
      req_ch.hop_start     = '0;
      req_ch.now_ms        = '0;
      req_ch.pending_match = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table under reset settings
      for (int r = 0; r < DIRECTED_ROWS; r++)
         offer_item(directed_rows[r].it, directed_rows[r].typed, directed_rows[r].want);

      // random phases, each under its own register settings
      now_clock = $urandom;
      for (int phase = 1; phase <= PHASES; phase++) begin
         settle_block();
         case (phase)
            1: begin
               retention_set = 32'h0;
               node_set = 32'hFFFF_FFFF;
               span = 3;
            end
            2: begin
               retention_set = 32'hFFFF_FFFF;
               node_set = 32'h1;
               span = 1000;
            end
            3: begin
               retention_set = 32'd1000;
               node_set = $urandom_range(32'hFFFF_FFFF, 1);
               span = 400;
            end
            4: begin
               retention_set = $urandom;
               node_set = $urandom_range(32'hFFFF_FFFF, 1);
               span = 5000;
            end
            default: begin
               retention_set = RETENTION_RESET;
               node_set = 32'h8000_0000;
               span = 60000;
            end
         endcase
         write_reg(REG_RETENTION, retention_set);
         write_reg(REG_OUR_NODE, node_set);

         // key pool: more keys than slots at times, so the table fills up
         pool_size = $urandom_range(8, POOL_MAX);
         for (int p = 0; p < pool_size; p++) begin
            case ($urandom_range(0, 5))
               0:       pool_src[p] = node_set;
               1:       pool_src[p] = 32'h0;
               2:       pool_src[p] = 32'hFFFF_FFFF;
               default: pool_src[p] = $urandom;
            endcase
            pool_id[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
         end

         if (phase == 2)
            hold_off_pending = 1'b1;

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // advance time, sometimes not at all, sometimes far or backwards
            case ($urandom_range(0, 19))
               0, 1:    now_clock = now_clock;
               2:       now_clock = now_clock + $urandom;
               3:       now_clock = now_clock - $urandom_range(1, span);
               default: now_clock = now_clock + $urandom_range(1, span);
            endcase
            k = $urandom_range(0, pool_size - 1);
            it.mode          = ($urandom_range(0, 7) == 0) ? MODE_RECORD : MODE_CHECK;
            it.source_node   = pool_src[k];
            it.packet_id     = pool_id[k];
            it.hop_limit     = 3'($urandom_range(0, 7));
            it.hop_start     = $urandom_range(0, 1) ? it.hop_limit : 3'($urandom_range(0, 7));
            it.now_ms        = now_clock;
            it.pending_match = 1'($urandom_range(0, 1));
            // stray packets with keys outside the pool
            if ($urandom_range(0, 7) == 0) begin
               it.source_node = $urandom;
               it.packet_id   = $urandom;
            end
            offer_item(it, 1'b0, '0);
         end
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d items sent (%0d record), %0d results checked, %0d of them hits",
               items_sent, record_items, results_checked, hit_results);
      $display("%0d register writes over %0d settings, %0d mismatches",
               config_writes, PHASES + 1, error_count);
      if (error_count == 0 && verdict_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
